### src/rmj_pkg.sv
`default_nettype none

package rmj_pkg;

  localparam int DataW      = 32;
  localparam int FracW      = 16;
  localparam int SqCells    = DataW;                          // root bits
  localparam int RangeCells = FracW + 1;                      // |p| / rho <= 1.0
  localparam int BrgCells   = DataW - 1;
  localparam int RateCells  = DataW - 1 + FracW;
  localparam int MulTail    = SqCells + RangeCells;           // t of the multiplier inputs
  localparam int SideLen    = MulTail + 1;
  localparam int BrgDly     = MulTail - BrgCells;
  localparam int RateDly    = MulTail - RateCells;

  localparam logic [DataW:0]     MagLim  = {2'b01, {(DataW - 1){1'b0}}};
  localparam logic [DataW:0]     PosMax  = {2'b00, {(DataW - 1){1'b1}}};
  localparam logic [2*DataW-FracW-1:0] RateCap = {1'b1, {(2*DataW-FracW-1){1'b0}}};

  // one restoring-division step
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] den;
    logic [63:0] num;   // dividend bits still to shift in, MSB first
    logic [63:0] quo;
  } div_t;

  // one digit-by-digit square-root step
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic vjac;
    logic sx;
    logic sy;
    logic ypos;
    logic sc;
    logic satbx;
    logic satby;
    logic satq;
  } side_t;

  function automatic logic [DataW-1:0] sat_out(input logic neg, input logic [DataW:0] m);
    logic [DataW:0] mm;
    logic [DataW:0] ng;
    if (neg) begin
      mm = (m > MagLim) ? MagLim : m;
      ng = ~mm + 1'b1;
      sat_out = ng[DataW-1:0];
    end else begin
      mm = (m > PosMax) ? PosMax : m;
      sat_out = mm[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### src/rmj_sqrt_cell.sv
`default_nettype none

module rmj_sqrt_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  rmj_pkg::sq_t  d_i,
  output rmj_pkg::sq_t  d_o
);
  import rmj_pkg::*;

  logic [35:0] part;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;
  sq_t         d_d;
  sq_t         d_q;

  always_comb begin
    part  = {d_i.rem, d_i.rad[63:62]};
    trial = {2'b00, d_i.root, 2'b01};
    diff  = part - trial;
    ge    = (part >= trial);
    d_d.rem  = ge ? diff[33:0] : part[33:0];
    d_d.root = {d_i.root[30:0], ge};
    d_d.rad  = {d_i.rad[61:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

`default_nettype wire

### src/rmj_div_cell.sv
`default_nettype none

module rmj_div_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  rmj_pkg::div_t d_i,
  output rmj_pkg::div_t d_o
);
  import rmj_pkg::*;

  logic [64:0] part;
  logic [64:0] diff;
  logic        ge;
  div_t        d_d;
  div_t        d_q;

  always_comb begin
    part = {d_i.rem, d_i.num[63]};
    diff = part - {1'b0, d_i.den};
    ge   = (part >= {1'b0, d_i.den});
    d_d.rem = ge ? diff[63:0] : part[63:0];
    d_d.den = d_i.den;
    d_d.num = {d_i.num[62:0], 1'b0};
    d_d.quo = {d_i.quo[62:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

`default_nettype wire

### src/radar_measurement_jacobian.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------
// cfg      | cfg_valid_i / cfg_ready_o | cfg_data_i (min_range_sq, Q.32)
// in       | in_valid_i / in_ready_o   | pos_x_i pos_y_i vel_x_i vel_y_i (Q15.16)
// out      | out_valid_o / out_ready_i | eight Jacobian terms (Q15.16), jacobian_valid_o
//
// One transaction per cycle while the pipe advances; the path from input to output register runs
// through stages B and C, the 32-cell root chain, the 17-cell range divider and two multiply stages.
// Bearing (31 cells) and range-rate (47 cells) dividers run alongside and are delay-matched.
// The whole pipe advances together: it holds only while the output register is full and
// out_ready_i is low. Reset clears valid bits and sets min_range_sq to 430; no clearing pass.
`default_nettype none

module radar_measurement_jacobian (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rmj_pkg::DataW-1:0]   pos_x_i,
  input  logic signed [rmj_pkg::DataW-1:0]   pos_y_i,
  input  logic signed [rmj_pkg::DataW-1:0]   vel_x_i,
  input  logic signed [rmj_pkg::DataW-1:0]   vel_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rmj_pkg::DataW-1:0]   range_dx_o,
  output logic signed [rmj_pkg::DataW-1:0]   range_dy_o,
  output logic signed [rmj_pkg::DataW-1:0]   bearing_dx_o,
  output logic signed [rmj_pkg::DataW-1:0]   bearing_dy_o,
  output logic signed [rmj_pkg::DataW-1:0]   rate_dx_o,
  output logic signed [rmj_pkg::DataW-1:0]   rate_dy_o,
  output logic signed [rmj_pkg::DataW-1:0]   rate_dvx_o,
  output logic signed [rmj_pkg::DataW-1:0]   rate_dvy_o,
  output logic                               jacobian_valid_o
);
  import rmj_pkg::*;

  logic        adv;
  logic [31:0] thr_q;

  // ---- stage B: magnitudes and raw products
  logic signed [63:0] xx_d, yy_d, vxy_d, vyx_d;
  logic signed [63:0] xx_q, yy_q, vxy_q, vyx_q;
  logic [31:0]        ax_d, ay_d, axb_q, ayb_q;
  logic               sxb_q, syb_q, vb_q;

  // ---- stage C (t = 0): squared range, cross term
  logic [63:0] p_d, p_q;
  logic [64:0] c_d, cn_d;
  logic [63:0] ac_d, ac_q;
  logic [31:0] ax_q, ay_q;
  logic        sx_q, sy_q, sc_q, vjac_q, vc_q;

  side_t       side_d;
  side_t       side_q [SideLen];
  logic [SideLen-1:0] vl_q;

  // ---- cell chains
  sq_t         sq_c  [SqCells+1];
  div_t        bx_c  [BrgCells+1];
  div_t        by_c  [BrgCells+1];
  div_t        q_c   [RateCells+1];
  div_t        rx_c  [RangeCells+1];
  div_t        ry_c  [RangeCells+1];

  logic [63:0] axy_q [SqCells];
  logic [61:0] brg_q [BrgDly];
  logic [46:0] qd_q  [RateDly];

  // ---- multiply stages
  side_t       s49, s50;
  logic [47:0] qsel;
  logic [16:0] rx_w, ry_w, rx_m_q, ry_m_q;
  logic [32:0] bx_w, by_w, bx_m_q, by_m_q;
  logic [40:0] pp_yh_q, pp_yl_q, pp_xh_q, pp_xl_q;
  logic [64:0] prod_y, prod_x;
  logic [32:0] rate_y, rate_x;

  logic        out_valid_q;
  logic [31:0] range_dx_d, range_dy_d, bearing_dx_d, bearing_dy_d, rate_dx_d, rate_dy_d;
  logic [31:0] range_dx_q, range_dy_q, bearing_dx_q, bearing_dy_q, rate_dx_q, rate_dy_q;
  logic        jac_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd430;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---- stage B
  always_comb begin
    ax_d  = pos_x_i[31] ? (~pos_x_i + 32'd1) : pos_x_i;
    ay_d  = pos_y_i[31] ? (~pos_y_i + 32'd1) : pos_y_i;
    xx_d  = pos_x_i * pos_x_i;
    yy_d  = pos_y_i * pos_y_i;
    vxy_d = vel_x_i * pos_y_i;
    vyx_d = vel_y_i * pos_x_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q  <= xx_d;
      yy_q  <= yy_d;
      vxy_q <= vxy_d;
      vyx_q <= vyx_d;
      axb_q <= ax_d;
      ayb_q <= ay_d;
      sxb_q <= pos_x_i[31];
      syb_q <= pos_y_i[31];
    end
  end

  // ---- stage C
  always_comb begin
    p_d  = $unsigned(xx_q) + $unsigned(yy_q);
    c_d  = {vxy_q[63], vxy_q} - {vyx_q[63], vyx_q};
    cn_d = {vyx_q[63], vyx_q} - {vxy_q[63], vxy_q};
    ac_d = c_d[64] ? cn_d[63:0] : c_d[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q    <= p_d;
      ac_q   <= ac_d;
      sc_q   <= c_d[64];
      ax_q   <= axb_q;
      ay_q   <= ayb_q;
      sx_q   <= sxb_q;
      sy_q   <= syb_q;
      vjac_q <= (p_d > {32'd0, thr_q});
    end
  end

  // flags that travel with the item; saturation tests avoid dividing past the output range
  always_comb begin
    side_d.vjac  = vjac_q;
    side_d.sx    = sx_q;
    side_d.sy    = sy_q;
    side_d.ypos  = !sy_q && (ay_q != 32'd0);
    side_d.sc    = sc_q;
    side_d.satbx = ({31'd0, ay_q, 1'b0} >= p_q);
    side_d.satby = ({31'd0, ax_q, 1'b0} >= p_q);
    side_d.satq  = ({31'd0, ac_q[63:31]} >= p_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vl_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vb_q        <= in_valid_i;
      vc_q        <= vb_q;
      vl_q        <= {vl_q[SideLen-2:0], vc_q};
      out_valid_q <= vl_q[SideLen-1];
    end
  end

  // delay lines
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SideLen; k++) begin
        side_q[k] <= side_q[k-1];
      end
      axy_q[0] <= {ax_q, ay_q};
      for (int k = 1; k < SqCells; k++) begin
        axy_q[k] <= axy_q[k-1];
      end
      brg_q[0] <= {bx_c[BrgCells].quo[30:0], by_c[BrgCells].quo[30:0]};
      for (int k = 1; k < BrgDly; k++) begin
        brg_q[k] <= brg_q[k-1];
      end
      qd_q[0] <= q_c[RateCells].quo[46:0];
      for (int k = 1; k < RateDly; k++) begin
        qd_q[k] <= qd_q[k-1];
      end
    end
  end

  // chain heads
  assign sq_c[0] = '{rem: '0, root: '0, rad: p_q};
  assign bx_c[0] = '{rem: {31'd0, ay_q, 1'b0}, den: p_q, num: '0, quo: '0};
  assign by_c[0] = '{rem: {31'd0, ax_q, 1'b0}, den: p_q, num: '0, quo: '0};
  assign q_c[0]  = '{rem: {31'd0, ac_q[63:31]}, den: p_q, num: {ac_q[30:0], 33'd0}, quo: '0};
  assign rx_c[0] = '{rem: {33'd0, axy_q[SqCells-1][63:33]}, den: {32'd0, sq_c[SqCells].root},
                     num: {axy_q[SqCells-1][32], 63'd0}, quo: '0};
  assign ry_c[0] = '{rem: {33'd0, axy_q[SqCells-1][31:1]}, den: {32'd0, sq_c[SqCells].root},
                     num: {axy_q[SqCells-1][0], 63'd0}, quo: '0};

  for (genvar i = 0; i < SqCells; i++) begin : g_sq
    rmj_sqrt_cell u_cell (.clk_i(clk_i), .en_i(adv), .d_i(sq_c[i]), .d_o(sq_c[i+1]));
  end

  for (genvar i = 0; i < BrgCells; i++) begin : g_brg
    rmj_div_cell u_bx (.clk_i(clk_i), .en_i(adv), .d_i(bx_c[i]), .d_o(bx_c[i+1]));
    rmj_div_cell u_by (.clk_i(clk_i), .en_i(adv), .d_i(by_c[i]), .d_o(by_c[i+1]));
  end

  for (genvar i = 0; i < RateCells; i++) begin : g_rate
    rmj_div_cell u_q (.clk_i(clk_i), .en_i(adv), .d_i(q_c[i]), .d_o(q_c[i+1]));
  end

  for (genvar i = 0; i < RangeCells; i++) begin : g_rng
    rmj_div_cell u_rx (.clk_i(clk_i), .en_i(adv), .d_i(rx_c[i]), .d_o(rx_c[i+1]));
    rmj_div_cell u_ry (.clk_i(clk_i), .en_i(adv), .d_i(ry_c[i]), .d_o(ry_c[i+1]));
  end

  // ---- M1: partial products of range term times range-rate quotient
  assign s49 = side_q[SideLen-2];
  assign s50 = side_q[SideLen-1];

  always_comb begin
    qsel = s49.satq ? RateCap : {1'b0, qd_q[RateDly-1]};
    rx_w = rx_c[RangeCells].quo[16:0];
    ry_w = ry_c[RangeCells].quo[16:0];
    bx_w = s49.satbx ? MagLim : {2'b00, brg_q[BrgDly-1][61:31]};
    by_w = s49.satby ? MagLim : {2'b00, brg_q[BrgDly-1][30:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_m_q  <= rx_w;
      ry_m_q  <= ry_w;
      bx_m_q  <= bx_w;
      by_m_q  <= by_w;
      pp_yh_q <= 41'(ry_w * qsel[47:24]);
      pp_yl_q <= 41'(ry_w * qsel[23:0]);
      pp_xh_q <= 41'(rx_w * qsel[47:24]);
      pp_xl_q <= 41'(rx_w * qsel[23:0]);
    end
  end

  // ---- M2: sum, scale, saturate, sign
  always_comb begin
    prod_y = {pp_yh_q, 24'd0} + {24'd0, pp_yl_q};
    prod_x = {pp_xh_q, 24'd0} + {24'd0, pp_xl_q};
    rate_y = (prod_y[64:16] > {16'd0, MagLim}) ? MagLim : prod_y[48:16];
    rate_x = (prod_x[64:16] > {16'd0, MagLim}) ? MagLim : prod_x[48:16];
    range_dx_d   = sat_out(s50.sx, {16'd0, rx_m_q});
    range_dy_d   = sat_out(s50.sy, {16'd0, ry_m_q});
    bearing_dx_d = sat_out(s50.ypos, bx_m_q);
    bearing_dy_d = sat_out(s50.sx, by_m_q);
    rate_dx_d    = sat_out(s50.sy != s50.sc, rate_y);
    rate_dy_d    = sat_out(s50.sx == s50.sc, rate_x);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      range_dx_q   <= s50.vjac ? range_dx_d   : '0;
      range_dy_q   <= s50.vjac ? range_dy_d   : '0;
      bearing_dx_q <= s50.vjac ? bearing_dx_d : '0;
      bearing_dy_q <= s50.vjac ? bearing_dy_d : '0;
      rate_dx_q    <= s50.vjac ? rate_dx_d    : '0;
      rate_dy_q    <= s50.vjac ? rate_dy_d    : '0;
      jac_q        <= s50.vjac;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign range_dx_o       = range_dx_q;
  assign range_dy_o       = range_dy_q;
  assign bearing_dx_o     = bearing_dx_q;
  assign bearing_dy_o     = bearing_dy_q;
  assign rate_dx_o        = rate_dx_q;
  assign rate_dy_o        = rate_dy_q;
  assign rate_dvx_o       = range_dx_q;
  assign rate_dvy_o       = range_dy_q;
  assign jacobian_valid_o = jac_q;

  // ---- checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vb_q)
    else $error("accepted transaction did not enter the pipe");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vl_q) && $stable(vc_q))
    else $error("pipe moved during a stall");

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !jacobian_valid_o |-> range_dx_o == 0 && bearing_dx_o == 0 &&
    bearing_dy_o == 0 && rate_dx_o == 0 && rate_dy_o == 0 && range_dy_o == 0)
    else $error("nonzero Jacobian below threshold");

  a_range_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jacobian_valid_o |->
    range_dx_o <= 32'sh0001_0000 && range_dx_o >= -32'sh0001_0000)
    else $error("range term exceeds one");

endmodule

`default_nettype wire
